// ===== rtl/icim_pkg.sv =====
// Shared types and constants of the infrared code index matcher.
package icim_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int GROUP_W = 9;
    localparam logic [GROUP_W-1:0] GROUP_MAX = '1;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [2:0] STATUS_DONE  = 3'd0;
    localparam logic [2:0] STATUS_FULL  = 3'd1;
    localparam logic [2:0] STATUS_EXACT = 3'd2;
    localparam logic [2:0] STATUS_GROUP = 3'd3;
    localparam logic [2:0] STATUS_NONE  = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] protocol_key;
        logic [31:0] address;
        logic [31:0] command;
        logic [5:0]  entry_category;
        logic [9:0]  entry_button;
    } icim_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         match_category;
        logic [9:0]         match_button;
        logic [GROUP_W-1:0] member_count;
    } icim_rsp_t;

    // One stored table entry, as it sits in a word of the entry memory.
    typedef struct packed {
        logic [31:0] protocol_key;
        logic [31:0] address;
        logic [31:0] command;
        logic [5:0]  category;
        logic [9:0]  button;
    } icim_entry_t;

endpackage

// ===== rtl/icim_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module icim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ir_code_index_matcher.sv =====
// Top level of the infrared code index matcher: entry table and query scan.
//
// Usage: a request transfer happens at a rising edge where start is high and
// busy is low; the request struct carries the request type and its fields.
// Each request yields exactly one response, shown on the response struct for
// one cycle while done is high. The receiver cannot stall; it must take the
// response in that cycle.
// Clear and append complete at once: the response appears in the cycle after
// the transfer and busy stays low, so these requests can be issued every cycle.
// A query walks the entry memory in load order, one read per cycle through
// the single read port, and busy is high until the response appears.
// Reset empties the table by clearing the entry count; the memory itself is
// not cleared, since only entries below the count are ever read.
// An append writes one word at the count; a query reads only below the count
// and no append can start during a scan, so reads and writes never collide.
module ir_code_index_matcher #(
    parameter int TABLE_DEPTH = icim_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  icim_pkg::icim_req_t request,
    output logic                busy,
    output logic                done,
    output icim_pkg::icim_rsp_t response
);

    import icim_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(icim_entry_t);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            pend_reg, pend_next;
    logic [31:0]     q_hash_reg, q_hash_next;
    logic [31:0]     q_addr_reg, q_addr_next;
    logic [31:0]     q_cmd_reg, q_cmd_next;
    logic            have_first_reg, have_first_next;
    logic            have_exact_reg, have_exact_next;
    logic [5:0]      first_cat_reg, first_cat_next;
    logic [9:0]      first_btn_reg, first_btn_next;
    logic [5:0]      exact_cat_reg, exact_cat_next;
    logic [9:0]      exact_btn_reg, exact_btn_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic            done_reg, done_next;
    icim_rsp_t       rsp_reg, rsp_next;

    logic            wr_en;
    icim_entry_t     wr_entry;
    logic [EW-1:0]   rd_word;
    icim_entry_t     rd_entry;
    logic            accept;
    logic            issue_more;
    logic            hit;

    icim_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_word)
    );

    assign rd_entry = icim_entry_t'(rd_word);
    assign accept = start && (state_reg == ST_IDLE);
    assign issue_more = (issue_reg < count_reg);
    assign hit = pend_reg && (rd_entry.protocol_key == q_hash_reg)
                 && (rd_entry.address == q_addr_reg);

    always_comb
    begin
        wr_entry.protocol_key = request.protocol_key;
        wr_entry.address      = request.address;
        wr_entry.command      = request.command;
        wr_entry.category     = request.entry_category;
        wr_entry.button       = request.entry_button;
    end

    assign wr_en = accept && (request.req_type == REQ_APPEND) && (count_reg < DEPTH_C);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        q_hash_next     = q_hash_reg;
        q_addr_next     = q_addr_reg;
        q_cmd_next      = q_cmd_reg;
        have_first_next = have_first_reg;
        have_exact_next = have_exact_reg;
        first_cat_next  = first_cat_reg;
        first_btn_next  = first_btn_reg;
        exact_cat_next  = exact_cat_reg;
        exact_btn_next  = exact_btn_reg;
        group_next      = group_reg;
        done_next       = 1'b0;
        rsp_next        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (request.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        REQ_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg < DEPTH_C)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = STATUS_FULL;
                            end
                        end
                        REQ_QUERY:
                        begin
                            state_next      = ST_SCAN;
                            issue_next      = '0;
                            q_hash_next     = request.protocol_key;
                            q_addr_next     = request.address;
                            q_cmd_next      = request.command;
                            have_first_next = 1'b0;
                            have_exact_next = 1'b0;
                            group_next      = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle; the registered data returns in the next cycle.
                if (issue_more)
                begin
                    issue_next = issue_reg + 1'b1;
                    pend_next  = 1'b1;
                end

                if (hit)
                begin
                    if (group_reg != GROUP_MAX)
                    begin
                        group_next = group_reg + 1'b1;
                    end
                    if (!have_first_reg)
                    begin
                        have_first_next = 1'b1;
                        first_cat_next  = rd_entry.category;
                        first_btn_next  = rd_entry.button;
                    end
                    if (!have_exact_reg && (rd_entry.command == q_cmd_reg))
                    begin
                        have_exact_next = 1'b1;
                        exact_cat_next  = rd_entry.category;
                        exact_btn_next  = rd_entry.button;
                    end
                end

                // All reads issued and the last one compared: report.
                if (!issue_more && !pend_reg)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (have_exact_reg)
                    begin
                        rsp_next.status         = STATUS_EXACT;
                        rsp_next.match_category = exact_cat_reg;
                        rsp_next.match_button   = exact_btn_reg;
                        rsp_next.member_count   = group_reg;
                    end
                    else if (have_first_reg)
                    begin
                        rsp_next.status         = STATUS_GROUP;
                        rsp_next.match_category = first_cat_reg;
                        rsp_next.match_button   = first_btn_reg;
                        rsp_next.member_count   = group_reg;
                    end
                    else
                    begin
                        rsp_next.status = STATUS_NONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            pend_reg       <= 1'b0;
            have_first_reg <= 1'b0;
            have_exact_reg <= 1'b0;
            group_reg      <= '0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            have_first_reg <= have_first_next;
            have_exact_reg <= have_exact_next;
            group_reg      <= group_next;
            done_reg       <= done_next;
            rsp_reg        <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_hash_reg    <= q_hash_next;
        q_addr_reg    <= q_addr_next;
        q_cmd_reg     <= q_cmd_next;
        first_cat_reg <= first_cat_next;
        first_btn_reg <= first_btn_next;
        exact_cat_reg <= exact_cat_next;
        exact_btn_reg <= exact_btn_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign response = rsp_reg;

endmodule
